>>> src/bbc_pkg.sv
`timescale 1ns / 1ps

package bbc_pkg;

    // default sizes
    localparam int DEF_NUM_SLOTS  = 16;
    localparam int DEF_NUM_BLOCKS = 1024;

    // fixed field widths
    localparam int KIND_W   = 2;
    localparam int DEV_W    = 8;
    localparam int BLKNUM_W = 16;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 3;
    localparam int REFS_W   = 8;
    localparam int CNT_W    = 32;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNREF   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;

    localparam logic [REFS_W-1:0] REF_MAX = 8'd255;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // take the request beat into the request registers
        logic lookup;   // register tag compare and free vectors
        logic commit;   // update slots and counters, load the result beat
    } bbc_cmd_t;

endpackage

>>> src/bbc_ctrl.sv
`timescale 1ns / 1ps

module bbc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output bbc_pkg::bbc_cmd_t cmd
);
    import bbc_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOKUP = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;
    logic       accept;

    // result register can take a new beat
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == S_IDLE) || ((state_reg == S_COMMIT) && out_free);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    assign cmd.capture = accept;
    assign cmd.lookup  = (state_reg == S_LOOKUP);
    assign cmd.commit  = (state_reg == S_COMMIT) && out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (out_free) begin
                    state_next = accept ? S_LOOKUP : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result beat valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> src/bbc_datapath.sv
`timescale 1ns / 1ps

module bbc_datapath #(
    parameter int NUM_SLOTS  = bbc_pkg::DEF_NUM_SLOTS,
    parameter int NUM_BLOCKS = bbc_pkg::DEF_NUM_BLOCKS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bbc_pkg::bbc_cmd_t             cmd,
    input  logic [bbc_pkg::KIND_W-1:0]    s_kind,
    input  logic [bbc_pkg::DEV_W-1:0]     s_device_id,
    input  logic [bbc_pkg::BLKNUM_W-1:0]  s_block_number,
    input  logic [bbc_pkg::IDX_W-1:0]     s_slot_index,
    output logic [bbc_pkg::IDX_W-1:0]     m_result_slot,
    output logic                          m_was_hit,
    output logic                          m_fetch_needed,
    output logic                          m_store_needed,
    output logic [bbc_pkg::STATUS_W-1:0]  m_status,
    output logic [bbc_pkg::CNT_W-1:0]     m_hit_total,
    output logic [bbc_pkg::CNT_W-1:0]     m_miss_total,
    output logic [bbc_pkg::CNT_W-1:0]     m_disk_read_total,
    output logic [bbc_pkg::CNT_W-1:0]     m_disk_write_total
);
    import bbc_pkg::*;

    localparam int BW    = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1;
    localparam int ENC_W = $clog2(NUM_SLOTS);
    localparam int SEL_W = (ENC_W > IDX_W) ? ENC_W : IDX_W;

    // request registers
    logic [KIND_W-1:0]   kind_reg;
    logic [DEV_W-1:0]    dev_reg;
    logic [BLKNUM_W-1:0] blk_reg;
    logic [IDX_W-1:0]    idx_reg;

    // slot tag and reference state, one lane per slot
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [DEV_W-1:0]     sdev_reg  [NUM_SLOTS];
    logic [BW-1:0]        sblk_reg  [NUM_SLOTS];
    logic [REFS_W-1:0]    refs_reg  [NUM_SLOTS];

    // lookup results
    logic [NUM_SLOTS-1:0] match_reg, free_reg, sel_reg;
    logic                 range_ok_reg, idx_nz_reg, idx_valid_reg;
    logic [NUM_SLOTS-1:0] match_vec, free_vec, sel_vec;
    logic                 range_ok;

    // statistics
    logic [CNT_W-1:0] hit_cnt_reg, miss_cnt_reg, fetch_cnt_reg, store_cnt_reg;

    // result registers
    logic [IDX_W-1:0]    rslot_reg;
    logic                hit_reg, fetch_reg, store_reg;
    logic [STATUS_W-1:0] status_reg;

    // commit decisions
    logic [NUM_SLOTS-1:0] match_first, free_first;
    logic [NUM_SLOTS-1:0] inc_vec, dec_vec, claim_vec;
    logic [ENC_W-1:0]     match_enc, free_enc;
    logic [IDX_W-1:0]     rslot_next;
    logic                 hit_next, fetch_next, store_next;
    logic [STATUS_W-1:0]  status_next;

    assign range_ok = {1'b0, blk_reg} < (BLKNUM_W+1)'(NUM_BLOCKS);

    // per-lane tag compare, free test and slot select
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            match_vec[i] = (refs_reg[i] != '0) && (sdev_reg[i] == dev_reg)
                           && (sblk_reg[i] == blk_reg[BW-1:0]);
            free_vec[i]  = (refs_reg[i] == '0);
            sel_vec[i]   = (SEL_W'(idx_reg) == SEL_W'(i));
        end
    end

    // lowest set lane of each vector
    assign match_first = match_reg & (~match_reg + NUM_SLOTS'(1));
    assign free_first  = free_reg & (~free_reg + NUM_SLOTS'(1));

    always_comb begin
        match_enc = '0;
        free_enc  = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (match_first[i]) begin
                match_enc = match_enc | ENC_W'(i);
            end
            if (free_first[i]) begin
                free_enc = free_enc | ENC_W'(i);
            end
        end
    end

    // request outcome
    always_comb begin
        rslot_next  = '0;
        hit_next    = 1'b0;
        fetch_next  = 1'b0;
        store_next  = 1'b0;
        status_next = ST_OK;
        inc_vec     = '0;
        dec_vec     = '0;
        claim_vec   = '0;
        case (kind_reg)
            KIND_ACQUIRE: begin
                if (!range_ok_reg) begin
                    status_next = ST_RANGE;
                end else if (|match_reg) begin
                    hit_next   = 1'b1;
                    rslot_next = IDX_W'(match_enc);
                    inc_vec    = match_first;
                end else if (|free_reg) begin
                    fetch_next = 1'b1;
                    rslot_next = IDX_W'(free_enc);
                    claim_vec  = free_first;
                end else begin
                    status_next = ST_FULL;
                end
            end
            KIND_RELEASE: begin
                rslot_next = idx_reg;
                if (!idx_nz_reg) begin
                    status_next = ST_UNREF;
                end else begin
                    dec_vec = sel_reg;
                end
            end
            KIND_WRITE: begin
                rslot_next = idx_reg;
                if (!idx_valid_reg) begin
                    status_next = ST_INVALID;
                end else begin
                    store_next = 1'b1;
                end
            end
            default: begin
                rslot_next = '0;
            end
        endcase
    end

    // request capture, lookup registers and result beat
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= s_kind;
            dev_reg  <= s_device_id;
            blk_reg  <= s_block_number;
            idx_reg  <= s_slot_index;
        end
        if (cmd.lookup) begin
            match_reg     <= match_vec;
            free_reg      <= free_vec;
            sel_reg       <= sel_vec;
            range_ok_reg  <= range_ok;
            idx_nz_reg    <= |(sel_vec & ~free_vec);
            idx_valid_reg <= |(sel_vec & valid_reg);
        end
        if (cmd.commit) begin
            rslot_reg  <= rslot_next;
            hit_reg    <= hit_next;
            fetch_reg  <= fetch_next;
            store_reg  <= store_next;
            status_reg <= status_next;
        end
    end

    // slot lanes
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
                refs_reg[i]  <= '0;
            end else if (cmd.commit) begin
                if (claim_vec[i]) begin
                    valid_reg[i] <= 1'b1;
                    refs_reg[i]  <= REFS_W'(1);
                    sdev_reg[i]  <= dev_reg;
                    sblk_reg[i]  <= blk_reg[BW-1:0];
                end else if (inc_vec[i] && (refs_reg[i] != REF_MAX)) begin
                    refs_reg[i] <= refs_reg[i] + REFS_W'(1);
                end else if (dec_vec[i]) begin
                    refs_reg[i] <= refs_reg[i] - REFS_W'(1);
                end
            end
        end
    end

    // statistics counters, wrapping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            fetch_cnt_reg <= '0;
            store_cnt_reg <= '0;
        end else if (cmd.commit) begin
            if (hit_next) begin
                hit_cnt_reg <= hit_cnt_reg + CNT_W'(1);
            end
            if (fetch_next) begin
                miss_cnt_reg  <= miss_cnt_reg + CNT_W'(1);
                fetch_cnt_reg <= fetch_cnt_reg + CNT_W'(1);
            end
            if (store_next) begin
                store_cnt_reg <= store_cnt_reg + CNT_W'(1);
            end
        end
    end

    assign m_result_slot      = rslot_reg;
    assign m_was_hit          = hit_reg;
    assign m_fetch_needed     = fetch_reg;
    assign m_store_needed     = store_reg;
    assign m_status           = status_reg;
    // counters only move on a commit, which waits for the held beat to leave
    assign m_hit_total        = hit_cnt_reg;
    assign m_miss_total       = miss_cnt_reg;
    assign m_disk_read_total  = fetch_cnt_reg;
    assign m_disk_write_total = store_cnt_reg;

endmodule

>>> src/block_buffer_cache_tags.sv
`timescale 1ns / 1ps

// channel   direction  ports
// s_        in         s_valid s_ready s_kind s_device_id s_block_number s_slot_index
// m_        out        m_valid m_ready m_result_slot m_was_hit m_fetch_needed
//                      m_store_needed m_status m_hit_total m_miss_total
//                      m_disk_read_total m_disk_write_total
//
// each request takes a lookup step, the parallel tag compare across all slot lanes,
// and a commit step: the lowest-lane pick, the slot update and loading the result register
// a new request is taken in the commit cycle of the previous one, so a request can
// be accepted while the previous one finishes
// synchronous active-low reset empties every slot and zeroes the statistics
// a held result beat stalls the commit of the next request until it is taken

module block_buffer_cache_tags #(
    parameter int NUM_SLOTS  = bbc_pkg::DEF_NUM_SLOTS,
    parameter int NUM_BLOCKS = bbc_pkg::DEF_NUM_BLOCKS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bbc_pkg::KIND_W-1:0]    s_kind,
    input  logic [bbc_pkg::DEV_W-1:0]     s_device_id,
    input  logic [bbc_pkg::BLKNUM_W-1:0]  s_block_number,
    input  logic [bbc_pkg::IDX_W-1:0]     s_slot_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bbc_pkg::IDX_W-1:0]     m_result_slot,
    output logic                          m_was_hit,
    output logic                          m_fetch_needed,
    output logic                          m_store_needed,
    output logic [bbc_pkg::STATUS_W-1:0]  m_status,
    output logic [bbc_pkg::CNT_W-1:0]     m_hit_total,
    output logic [bbc_pkg::CNT_W-1:0]     m_miss_total,
    output logic [bbc_pkg::CNT_W-1:0]     m_disk_read_total,
    output logic [bbc_pkg::CNT_W-1:0]     m_disk_write_total
);
    import bbc_pkg::*;

    bbc_cmd_t cmd;

    // sequencing
    bbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // slot lanes, lookup and statistics
    bbc_datapath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .s_kind             (s_kind),
        .s_device_id        (s_device_id),
        .s_block_number     (s_block_number),
        .s_slot_index       (s_slot_index),
        .m_result_slot      (m_result_slot),
        .m_was_hit          (m_was_hit),
        .m_fetch_needed     (m_fetch_needed),
        .m_store_needed     (m_store_needed),
        .m_status           (m_status),
        .m_hit_total        (m_hit_total),
        .m_miss_total       (m_miss_total),
        .m_disk_read_total  (m_disk_read_total),
        .m_disk_write_total (m_disk_write_total)
    );

endmodule
